@@ sv/aabb_pkg.sv @@
`timescale 1ns / 1ps
package aabb_pkg;

    localparam int MAX_BODIES = 32;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);
    localparam int PROD_W     = 50;
    localparam int SUM_W      = 35;
    localparam int OV_W       = 35;

    localparam logic signed [31:0] GRAVITY_Y_RESET = -32'sd642908;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic [1:0] REG_GX = 2'd0;
    localparam logic [1:0] REG_GY = 2'd1;
    localparam logic [1:0] REG_GZ = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        size_x;
        logic [30:0]        size_y;
        logic [30:0]        size_z;
        logic               static_flag;
        logic [4:0]         slot;
        logic [16:0]        step_dt;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         out_slot;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_z;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][30:0] size;
        logic             stat;
    } t_body;

    typedef enum logic [1:0] {
        WS_NEW = 2'd0,
        WS_RD  = 2'd1,
        WS_B   = 2'd2,
        WS_A   = 2'd3
    } t_wsel;

    typedef enum logic [2:0] {
        EM_ADD_OK  = 3'd0,
        EM_FULL    = 3'd1,
        EM_REM_OK  = 3'd2,
        EM_NO_SLOT = 3'd3,
        EM_EMPTY   = 3'd4,
        EM_BODY    = 3'd5
    } t_emit;

    typedef struct packed {
        logic             latch;
        logic [IDX_W-1:0] raddr;
        logic             ram_we;
        logic [IDX_W-1:0] waddr;
        t_wsel            wsel;
        logic             load_a;
        logic             mul;
        logic             acc;
        logic [1:0]       ax;
        logic             int_pos;
        logic             load_b;
        logic             calc_d;
        logic             calc_ov;
        logic             calc_res;
        logic             apply;
        logic             emit;
        t_emit            emit_code;
        logic [IDX_W-1:0] emit_slot;
        logic             emit_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] slot;
        logic       rd_static;
        logic       b_static;
        logic       hit;
    } t_sts;

    function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [31:0] r;
        if (v > $signed({{(SUM_W-31){1'b0}}, {31{1'b1}}})) begin
            r = {1'b0, {31{1'b1}}};
        end else if (v < $signed({{(SUM_W-31){1'b1}}, {31{1'b0}}})) begin
            r = {1'b1, {31{1'b0}}};
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ sv/aabb_ram.sv @@
`timescale 1ns / 1ps
module aabb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/aabb_ctrl.sv @@
`timescale 1ns / 1ps
module aabb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  aabb_pkg::t_sts i_sts,
    output aabb_pkg::t_cmd o_cmd
);
    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_DISP     = 16'h0002,
        S_REM_WAIT = 16'h0004,
        S_I_RD     = 16'h0008,
        S_I_LOAD   = 16'h0010,
        S_MUL      = 16'h0020,
        S_ACC      = 16'h0040,
        S_J_CHK    = 16'h0080,
        S_J_LOAD   = 16'h0100,
        S_J_D      = 16'h0200,
        S_J_OV     = 16'h0400,
        S_J_RES    = 16'h0800,
        S_J_APPLY  = 16'h1000,
        S_WB       = 16'h2000,
        S_O_RD     = 16'h4000,
        S_O_EMIT   = 16'h8000
    } t_state;

    t_state                     r_state, n_state;
    logic [aabb_pkg::CNT_W-1:0] r_count, n_count;
    logic [aabb_pkg::CNT_W-1:0] r_i, n_i, r_j, n_j, r_o, n_o;
    logic [2:0]                 r_ax, n_ax;
    aabb_pkg::t_cmd             cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_o     <= '0;
            r_ax    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_i     <= n_i;
            r_j     <= n_j;
            r_o     <= n_o;
            r_ax    <= n_ax;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_i     = r_i;
        n_j     = r_j;
        n_o     = r_o;
        n_ax    = r_ax;
        cmd     = '0;
        cmd.ax      = (r_ax < 3'd3) ? r_ax[1:0] : 2'(r_ax - 3'd3);
        cmd.int_pos = (r_ax >= 3'd3);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.kind)
                    aabb_pkg::KIND_ADD: begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        if (r_count == aabb_pkg::CNT_W'(aabb_pkg::MAX_BODIES)) begin
                            cmd.emit_code = aabb_pkg::EM_FULL;
                        end else begin
                            cmd.ram_we    = 1'b1;
                            cmd.waddr     = r_count[aabb_pkg::IDX_W-1:0];
                            cmd.wsel      = aabb_pkg::WS_NEW;
                            cmd.emit_code = aabb_pkg::EM_ADD_OK;
                            cmd.emit_slot = r_count[aabb_pkg::IDX_W-1:0];
                            n_count       = r_count + 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                    aabb_pkg::KIND_REMOVE: begin
                        if (aabb_pkg::CNT_W'(i_sts.slot) >= r_count) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            cmd.emit_code = aabb_pkg::EM_NO_SLOT;
                            n_state       = S_IDLE;
                        end else begin
                            // fetch the last body to fill the hole
                            cmd.raddr = aabb_pkg::IDX_W'(r_count - 1'b1);
                            n_state   = S_REM_WAIT;
                        end
                    end
                    default: begin
                        if (r_count == '0) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            cmd.emit_code = aabb_pkg::EM_EMPTY;
                            n_state       = S_IDLE;
                        end else begin
                            n_i     = '0;
                            n_state = S_I_RD;
                        end
                    end
                endcase
            end
            S_REM_WAIT: begin
                cmd.ram_we    = 1'b1;
                cmd.waddr     = aabb_pkg::IDX_W'(i_sts.slot);
                cmd.wsel      = aabb_pkg::WS_RD;
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                cmd.emit_code = aabb_pkg::EM_REM_OK;
                n_count       = r_count - 1'b1;
                n_state       = S_IDLE;
            end
            S_I_RD: begin
                if (r_i == r_count) begin
                    n_o     = '0;
                    n_state = S_O_RD;
                end else begin
                    cmd.raddr = r_i[aabb_pkg::IDX_W-1:0];
                    n_state   = S_I_LOAD;
                end
            end
            S_I_LOAD: begin
                cmd.load_a = 1'b1;
                if (i_sts.rd_static) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_I_RD;
                end else begin
                    n_ax    = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                if (r_ax == 3'd5) begin
                    n_j     = '0;
                    n_state = S_J_CHK;
                end else begin
                    n_ax    = r_ax + 3'd1;
                    n_state = S_MUL;
                end
            end
            S_J_CHK: begin
                if (r_j == r_count) begin
                    n_state = S_WB;
                end else if (r_j == r_i) begin
                    n_j = r_j + 1'b1;
                end else begin
                    cmd.raddr = r_j[aabb_pkg::IDX_W-1:0];
                    n_state   = S_J_LOAD;
                end
            end
            S_J_LOAD: begin
                cmd.load_b = 1'b1;
                n_state    = S_J_D;
            end
            S_J_D: begin
                cmd.calc_d = 1'b1;
                n_state    = S_J_OV;
            end
            S_J_OV: begin
                cmd.calc_ov = 1'b1;
                n_state     = S_J_RES;
            end
            S_J_RES: begin
                cmd.calc_res = 1'b1;
                n_state      = S_J_APPLY;
            end
            S_J_APPLY: begin
                if (i_sts.hit) begin
                    cmd.apply = 1'b1;
                    if (!i_sts.b_static) begin
                        cmd.ram_we = 1'b1;
                        cmd.waddr  = r_j[aabb_pkg::IDX_W-1:0];
                        cmd.wsel   = aabb_pkg::WS_B;
                    end
                end
                n_j     = r_j + 1'b1;
                n_state = S_J_CHK;
            end
            S_WB: begin
                cmd.ram_we = 1'b1;
                cmd.waddr  = r_i[aabb_pkg::IDX_W-1:0];
                cmd.wsel   = aabb_pkg::WS_A;
                n_i        = r_i + 1'b1;
                n_state    = S_I_RD;
            end
            S_O_RD: begin
                cmd.raddr = r_o[aabb_pkg::IDX_W-1:0];
                n_state   = S_O_EMIT;
            end
            S_O_EMIT: begin
                cmd.emit      = 1'b1;
                cmd.emit_code = aabb_pkg::EM_BODY;
                cmd.emit_slot = r_o[aabb_pkg::IDX_W-1:0];
                cmd.emit_last = (r_o == r_count - 1'b1);
                if (cmd.emit_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_o     = r_o + 1'b1;
                    n_state = S_O_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= aabb_pkg::CNT_W'(aabb_pkg::MAX_BODIES))
        else $error("body count above table size");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_count != $past(r_count) |->
        (r_count == $past(r_count) + 1'b1 || r_count == $past(r_count) - 1'b1))
        else $error("body count jumped");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit && cmd.emit_last |=> r_state == S_IDLE)
        else $error("last result without return to idle");
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !cmd.ram_we)
        else $error("table write while idle");
endmodule

@@ sv/aabb_dp.sv @@
`timescale 1ns / 1ps
module aabb_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  aabb_pkg::t_in          i_item,
    input  logic [2:0][31:0]       i_grav,
    input  aabb_pkg::t_cmd         i_cmd,
    output aabb_pkg::t_sts         o_sts,
    output logic                   o_valid,
    output aabb_pkg::t_out         o_result
);
    localparam int BODY_W = $bits(aabb_pkg::t_body);

    aabb_pkg::t_in   r_item;
    aabb_pkg::t_body r_a, n_a, r_b;
    aabb_pkg::t_body w_rd, w_new, w_bnew, w_wdata;
    logic [BODY_W-1:0] w_rdata;

    logic signed [aabb_pkg::PROD_W-1:0] r_prod, w_prod;
    logic [31:0]                        w_op, w_tgt, w_acc;
    logic signed [aabb_pkg::SUM_W-1:0]  w_sum;

    logic [2:0][32:0]               r_d;
    logic [2:0][aabb_pkg::OV_W-1:0] r_ov;
    logic [2:0]                     r_dneg;
    logic [2:0][32:0]               w_ad;
    logic [2:0]                     w_pos_ok;
    logic [1:0]                     r_axis, w_axis;
    logic                           r_hit, r_neg;
    logic [32:0]                    r_push;
    logic [aabb_pkg::OV_W-1:0]      w_ovsel;
    logic [33:0]                    w_mag, w_sdelta;
    logic [31:0]                    w_apos, w_bpos;

    aabb_pkg::t_out r_out, n_out;
    logic           r_valid;

    aabb_ram #(.WIDTH(BODY_W), .DEPTH(aabb_pkg::MAX_BODIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.ram_we),
        .i_waddr(i_cmd.waddr),
        .i_wdata(w_wdata),
        .i_raddr(i_cmd.raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd = aabb_pkg::t_body'(w_rdata);

    always_comb begin
        w_new      = '0;
        w_new.pos  = {r_item.pos_z, r_item.pos_y, r_item.pos_x};
        w_new.size = {r_item.size_z, r_item.size_y, r_item.size_x};
        w_new.stat = r_item.static_flag;
    end

    // shared multiplier: gravity or velocity times step time
    assign w_op   = i_cmd.int_pos ? r_a.vel[i_cmd.ax] : i_grav[i_cmd.ax];
    assign w_prod = $signed(w_op) * $signed({1'b0, r_item.step_dt});
    assign w_tgt  = i_cmd.int_pos ? r_a.pos[i_cmd.ax] : r_a.vel[i_cmd.ax];
    assign w_sum  = $signed({{3{w_tgt[31]}}, w_tgt})
                  + $signed({r_prod[aabb_pkg::PROD_W-1], r_prod[aabb_pkg::PROD_W-1:aabb_pkg::FRAC_BITS]});
    assign w_acc  = aabb_pkg::sat32(w_sum);

    // pair test: magnitudes and axis choice
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_ad[k]     = r_d[k][32] ? (~r_d[k] + 33'd1) : r_d[k];
            w_pos_ok[k] = !r_ov[k][aabb_pkg::OV_W-1] && (r_ov[k] != '0);
        end
        if (r_ov[0] < r_ov[1] && r_ov[0] < r_ov[2]) begin
            w_axis = 2'd0;
        end else if (r_ov[1] < r_ov[0] && r_ov[1] < r_ov[2]) begin
            w_axis = 2'd1;
        end else begin
            w_axis = 2'd2;
        end
        w_ovsel = r_ov[w_axis] + aabb_pkg::OV_W'(1);
    end

    assign w_mag    = r_b.stat ? {1'b0, r_push} : {2'b00, r_push[32:1]};
    assign w_sdelta = r_neg ? (~w_mag + 34'd1) : w_mag;
    assign w_apos   = aabb_pkg::sat32($signed({{3{r_a.pos[r_axis][31]}}, r_a.pos[r_axis]})
                                      + $signed({w_sdelta[33], w_sdelta}));
    assign w_bpos   = aabb_pkg::sat32($signed({{3{r_b.pos[r_axis][31]}}, r_b.pos[r_axis]})
                                      - $signed({w_sdelta[33], w_sdelta}));

    always_comb begin
        w_bnew              = r_b;
        w_bnew.pos[r_axis]  = w_bpos;
    end

    always_comb begin
        case (i_cmd.wsel)
            aabb_pkg::WS_NEW: w_wdata = w_new;
            aabb_pkg::WS_RD:  w_wdata = w_rd;
            aabb_pkg::WS_B:   w_wdata = w_bnew;
            aabb_pkg::WS_A:   w_wdata = r_a;
            default:          w_wdata = r_a;
        endcase
    end

    always_comb begin
        n_a = r_a;
        if (i_cmd.load_a) begin
            n_a = w_rd;
        end
        if (i_cmd.acc) begin
            if (i_cmd.int_pos) begin
                n_a.pos[i_cmd.ax] = w_acc;
            end else begin
                n_a.vel[i_cmd.ax] = w_acc;
            end
        end
        if (i_cmd.apply) begin
            n_a.pos[r_axis] = w_apos;
            if (r_b.stat) begin
                n_a.vel[r_axis] = '0;
            end
        end
    end

    always_comb begin
        n_out          = '0;
        n_out.out_slot = i_cmd.emit_slot;
        n_out.last     = i_cmd.emit_last;
        case (i_cmd.emit_code)
            aabb_pkg::EM_ADD_OK: begin
                n_out.status    = aabb_pkg::ST_OK;
                n_out.out_pos_x = r_item.pos_x;
                n_out.out_pos_y = r_item.pos_y;
                n_out.out_pos_z = r_item.pos_z;
            end
            aabb_pkg::EM_FULL: n_out.status = aabb_pkg::ST_FULL;
            aabb_pkg::EM_REM_OK: begin
                n_out.status   = aabb_pkg::ST_OK;
                n_out.out_slot = r_item.slot;
            end
            aabb_pkg::EM_NO_SLOT: begin
                n_out.status   = aabb_pkg::ST_NO_SLOT;
                n_out.out_slot = r_item.slot;
            end
            aabb_pkg::EM_EMPTY: n_out.status = aabb_pkg::ST_EMPTY;
            aabb_pkg::EM_BODY: begin
                n_out.status    = aabb_pkg::ST_OK;
                n_out.out_pos_x = w_rd.pos[0];
                n_out.out_pos_y = w_rd.pos[1];
                n_out.out_pos_z = w_rd.pos[2];
                n_out.out_vel_x = w_rd.vel[0];
                n_out.out_vel_y = w_rd.vel[1];
                n_out.out_vel_z = w_rd.vel[2];
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        r_a <= n_a;
        if (i_cmd.load_b) begin
            r_b <= w_rd;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.calc_d) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= $signed({r_a.pos[k][31], r_a.pos[k]})
                        - $signed({r_b.pos[k][31], r_b.pos[k]});
            end
        end
        if (i_cmd.calc_ov) begin
            for (int k = 0; k < 3; k++) begin
                r_ov[k]   <= {4'd0, r_a.size[k]} + {4'd0, r_b.size[k]}
                           - {1'b0, w_ad[k], 1'b0};
                r_dneg[k] <= r_d[k][32] || (r_d[k] == '0);
            end
        end
        if (i_cmd.calc_res) begin
            r_axis <= w_axis;
            r_neg  <= r_dneg[w_axis];
            r_push <= w_ovsel[33:1];
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.calc_res) begin
                r_hit <= &w_pos_ok;
            end
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.kind      = r_item.kind;
        o_sts.slot      = r_item.slot;
        o_sts.rd_static = w_rd.stat;
        o_sts.b_static  = r_b.stat;
        o_sts.hit       = r_hit;
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;
endmodule

@@ sv/aabb_body_physics_step_top.sv @@
`timescale 1ns / 1ps
// Box body table with gravity integration and overlap push-out. An item is
// taken when start is high and busy is low; busy then stays high until the
// item's last result is on the ports. Results appear on o_result for one
// cycle each, flagged by o_valid, with last set on the final one; the
// receiver cannot stall them, so sample every o_valid cycle. Busy covers
// the dispatch state on an add, and dispatch plus the table write state on
// a remove of a slot in use; the result is out in the cycle busy falls. A
// step over n bodies with m of them dynamic takes its length from the one
// read port of the body RAM that every pair test reads once, the pair test's
// load, difference, overlap, resolve and apply states, and the one shared
// multiplier used for six products per dynamic body. Gravity registers sit
// at byte addresses 0, 4 and 8 and may only be written while busy is low.
module aabb_body_physics_step_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  aabb_pkg::t_in  i_item,
    output logic           o_valid,
    output aabb_pkg::t_out o_result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    logic [2:0][31:0] r_grav;
    logic             w_wr;
    aabb_pkg::t_cmd   w_cmd;
    aabb_pkg::t_sts   w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // register file: write on the access phase, ignore unknown offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav[0] <= '0;
            r_grav[1] <= aabb_pkg::GRAVITY_Y_RESET;
            r_grav[2] <= '0;
        end else if (w_wr) begin
            case (paddr[3:2])
                aabb_pkg::REG_GX: r_grav[0] <= pwdata;
                aabb_pkg::REG_GY: r_grav[1] <= pwdata;
                aabb_pkg::REG_GZ: r_grav[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            aabb_pkg::REG_GX: prdata = r_grav[0];
            aabb_pkg::REG_GY: prdata = r_grav[1];
            aabb_pkg::REG_GZ: prdata = r_grav[2];
            default:          prdata = '0;
        endcase
    end

    // sequencer: walks bodies and pairs, issues datapath commands
    aabb_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .o_busy (busy),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    // datapath: body RAM, working body, multiplier, overlap pipeline
    aabb_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_grav  (r_grav),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_valid (o_valid),
        .o_result(o_result)
    );
endmodule
